// File: design/pfba_pkg.sv
// Shared types and constants for the page frame bitmap allocator.
// Depends on nothing; used by the controller, datapath and top level.
package pfba_pkg;

	localparam logic [2:0] OP_ALLOC_ONE = 3'd0;
	localparam logic [2:0] OP_ALLOC_RUN = 3'd1;
	localparam logic [2:0] OP_FREE      = 3'd2;
	localparam logic [2:0] OP_LOCK      = 3'd3;
	localparam logic [2:0] OP_RESERVE   = 3'd4;
	localparam logic [2:0] OP_UNRESERVE = 3'd5;

	localparam int CNT_W = 17;
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] page_index;
		logic [16:0] page_count;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] start_page;
		logic [16:0] free_pages;
		logic [16:0] used_pages;
		logic [16:0] reserved_pages;
	} rsp_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;   // capture request, start operation
		logic step;   // perform one page step
		logic clear;  // memory clearing pass step
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic done;       // operation finished this cycle
		logic clear_done; // clearing pass finished
	} sts_t;

endpackage

// File: design/pfba_ctrl.sv
// Controller state machine for the page frame bitmap allocator.
// Depends on pfba_pkg.
module pfba_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output pfba_pkg::cmd_t  cmd,
	input  pfba_pkg::sts_t  sts
);
	import pfba_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;

	logic [1:0] state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: if (sts.clear_done) state_q <= ST_IDLE;
				ST_IDLE:  if (start) state_q <= ST_RUN;
				ST_RUN:   if (sts.done) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign cmd.load  = (state_q == ST_IDLE) && start;
	assign cmd.step  = (state_q == ST_RUN);
	assign cmd.clear = (state_q == ST_CLEAR);
endmodule

// File: design/pfba_datapath.sv
// Datapath of the page frame bitmap allocator: bitmap memory, hint, counters.
// Depends on pfba_pkg.
module pfba_datapath #(
	parameter int PAGES     = 65536,
	parameter int WORD_BITS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pfba_pkg::cmd_t cmd,
	output pfba_pkg::sts_t sts,
	input  pfba_pkg::req_t req,
	output logic           result_valid,
	output pfba_pkg::rsp_t result
);
	import pfba_pkg::*;

	localparam int WORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BW    = $clog2(WORD_BITS);
	localparam int PW    = $clog2(PAGES) + 2;
	localparam logic [PW-1:0] PAGES_P = PW'(PAGES);
	localparam logic [CNT_W-1:0] FREE_RESET =
		(PAGES > 131071) ? COUNT_MAX : CNT_W'(PAGES);

	// Each page step reads the word in its first phase, then modifies and writes it in its second.
	logic [WORD_BITS-1:0] mem [WORDS];
	logic [WORD_BITS-1:0] rd_q;
	logic [AW-1:0]        clr_addr_q;
	logic                 phase_q;
	logic [2:0]           op_q;
	logic [PW-1:0]        idx_q;      // current page of a range
	logic [PW-1:0]        rem_q;      // pages left in range or run
	logic [PW-1:0]        cnt_q;      // run length
	logic [PW-1:0]        run_start_q;
	logic [PW-1:0]        hint_q;
	logic [CNT_W-1:0]     free_q, used_q, rsv_q;
	logic                 take_q;     // alloc run: found clear run, now marking
	logic                 ok_q;
	logic [15:0]          start_q;

	logic [PW-1:0]        page;
	logic [AW-1:0]        waddr;
	logic [BW-1:0]        bsel;
	logic                 bit_v;
	logic                 is_alloc_one, is_run, is_give, other_rsv;

	assign is_alloc_one = (op_q == OP_ALLOC_ONE);
	assign is_run       = (op_q == OP_ALLOC_RUN);
	assign is_give      = (op_q == OP_FREE) || (op_q == OP_UNRESERVE);
	assign other_rsv    = (op_q == OP_RESERVE) || (op_q == OP_UNRESERVE);

	always_comb begin
		if (is_alloc_one)
			page = hint_q;
		else if (is_run)
			page = take_q ? idx_q : hint_q + (cnt_q - rem_q);
		else
			page = idx_q;
	end
	assign waddr = AW'(page / WORD_BITS);
	assign bsel  = BW'(page % WORD_BITS);
	assign bit_v = rd_q[bsel];

	function automatic logic [CNT_W-1:0] inc(input logic [CNT_W-1:0] c);
		return (c == COUNT_MAX) ? c : c + 1'b1;
	endfunction
	function automatic logic [CNT_W-1:0] dec(input logic [CNT_W-1:0] c);
		return (c == '0) ? c : c - 1'b1;
	endfunction

	// Step decision in the second phase.
	logic fin, ok_n, wr_en, wr_val;
	logic [PW-1:0] start_n;
	always_comb begin
		fin = 1'b0; ok_n = 1'b1; wr_en = 1'b0; wr_val = 1'b0; start_n = '0;
		if (is_alloc_one) begin
			if (!bit_v) begin
				wr_en = 1'b1; wr_val = 1'b1; fin = 1'b1; start_n = hint_q;
			end
		end else if (is_run) begin
			if (take_q) begin
				wr_en = !bit_v; wr_val = 1'b1;
				fin = (rem_q == PW'(1)); start_n = run_start_q;
			end
		end else begin
			wr_val = !is_give;
			wr_en = is_give ? bit_v : !bit_v;
			fin = (rem_q == PW'(1)) || (idx_q + 1'b1 >= PAGES_P);
		end
	end

	// Pre-checks done at the top of each step (phase 0).
	logic pre_fin, pre_ok;
	always_comb begin
		pre_fin = 1'b0; pre_ok = 1'b1;
		if (is_alloc_one) begin
			if (hint_q >= PAGES_P) begin
				pre_fin = 1'b1; pre_ok = 1'b0;
			end
		end else if (is_run) begin
			if (!take_q && (cnt_q == '0 || hint_q > PAGES_P ||
				cnt_q > PAGES_P - hint_q)) begin
				pre_fin = 1'b1; pre_ok = 1'b0;
			end
		end else if (op_q > OP_UNRESERVE) begin
			pre_fin = 1'b1; pre_ok = 1'b0;
		end else if (rem_q == '0 || idx_q >= PAGES_P) begin
			pre_fin = 1'b1;
		end
	end

	logic done;
	assign done = cmd.step && ((!phase_q && pre_fin) || (phase_q && fin));

	always_ff @(posedge clk) begin
		if (cmd.clear)
			mem[clr_addr_q] <= '0;
		else if (cmd.step && phase_q && wr_en)
			mem[waddr][bsel] <= wr_val;
		rd_q <= mem[waddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q   <= '0;
			phase_q      <= 1'b0;
			op_q         <= '0;
			idx_q        <= '0;
			rem_q        <= '0;
			cnt_q        <= '0;
			run_start_q  <= '0;
			hint_q       <= '0;
			free_q       <= FREE_RESET;
			used_q       <= '0;
			rsv_q        <= '0;
			take_q       <= 1'b0;
			result_valid <= 1'b0;
			ok_q         <= 1'b0;
			start_q      <= '0;
		end else begin
			result_valid <= done;
			if (done) begin
				ok_q    <= phase_q ? ok_n : pre_ok;
				start_q <= phase_q ? start_n[15:0] : 16'd0;
			end
			if (cmd.clear)
				clr_addr_q <= clr_addr_q + 1'b1;
			if (cmd.load) begin
				phase_q <= 1'b0;
				take_q  <= 1'b0;
				op_q    <= req.opcode;
				idx_q   <= PW'(req.page_index);
				rem_q   <= PW'(req.page_count);
				cnt_q   <= PW'(req.page_count);
			end else if (cmd.step) begin
				if (!phase_q) begin
					if (!pre_fin)
						phase_q <= 1'b1;
				end else begin
					phase_q <= 1'b0;
					if (wr_en) begin
						if (wr_val) begin
							free_q <= dec(free_q);
							if (other_rsv) rsv_q <= inc(rsv_q);
							else used_q <= inc(used_q);
						end else begin
							free_q <= inc(free_q);
							if (other_rsv) rsv_q <= dec(rsv_q);
							else used_q <= dec(used_q);
							if (hint_q > page) hint_q <= page;
						end
					end
					if (is_alloc_one) begin
						if (bit_v) hint_q <= hint_q + 1'b1;
					end else if (is_run) begin
						if (take_q) begin
							idx_q <= idx_q + 1'b1;
							rem_q <= rem_q - 1'b1;
							if (fin) hint_q <= run_start_q + cnt_q;
						end else if (bit_v) begin
							hint_q <= page + 1'b1;
							rem_q  <= cnt_q;
						end else if (rem_q == PW'(1)) begin
							take_q      <= 1'b1;
							run_start_q <= hint_q;
							idx_q       <= hint_q;
							rem_q       <= cnt_q;
						end else begin
							rem_q <= rem_q - 1'b1;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
						rem_q <= rem_q - 1'b1;
					end
				end
			end
		end
	end

	assign result.ok             = ok_q;
	assign result.start_page     = start_q;
	assign result.free_pages     = free_q;
	assign result.used_pages     = used_q;
	assign result.reserved_pages = rsv_q;

	assign sts.done       = done;
	assign sts.clear_done = cmd.clear && (clr_addr_q == AW'(WORDS - 1));
endmodule

// File: design/page_frame_bitmap_allocator.sv
// Top level of the page frame bitmap allocator.
// Depends on pfba_pkg, pfba_ctrl and pfba_datapath.
//
// A request transaction is taken when start is high and busy is low; the
// request struct holds the opcode, first page and page count. Exactly one
// result transaction follows, shown on result for one cycle while
// result_valid is high; the receiver cannot stall it, so it must take it.
// The block handles one request at a time and stays busy until the result
// has been produced.
// Every page visited has its bitmap word read from the single-port memory,
// then modified and written back. Allocation runs that hit a taken page
// restart their check just past it.
// After reset the block runs a clearing pass over the bitmap, one word per
// cycle, holding busy high; the hint and counters reset at once to zero,
// PAGES free (saturated at COUNT_MAX), zero used and zero reserved.
module page_frame_bitmap_allocator #(
	parameter int PAGES     = 65536,
	parameter int WORD_BITS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  pfba_pkg::req_t request,
	output logic           result_valid,
	output pfba_pkg::rsp_t result
);
	import pfba_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pfba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	pfba_datapath #(.PAGES(PAGES), .WORD_BITS(WORD_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req          (request),
		.result_valid (result_valid),
		.result       (result)
	);
endmodule
